// ===== rtl/hsra_pkg.sv =====
package hsra_pkg;

  localparam int HEAP_W    = 3;
  localparam int OFF_W     = 10;
  localparam int VAL_W     = 11;
  localparam int CFG_W     = 11;
  localparam int MAX_HEAPS = 8;
  localparam int OPEN_W    = $clog2(MAX_HEAPS + 1);
  localparam int MAX_SLOTS = 1024;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_HEAPS_FULL = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_HEAP   = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [HEAP_W-1:0] free_heap;
    logic [OFF_W-1:0]  free_offset;
  } in_item_t;

  typedef struct packed {
    logic [HEAP_W-1:0] heap_index;
    logic [OFF_W-1:0]  slot_offset;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] start;
    logic [VAL_W-1:0] stop;
  } range_t;

endpackage

// ===== rtl/heap_slot_range_allocator.sv =====
// Single-slot allocator over eight heaps, each with an ordered list of free
// slot ranges held in one synchronous RAM (start and end per entry). One item
// is worked at a time. An allocate from an open heap passes A_CHK, with an
// SH_RD and SH_WR pass per remaining range if the front range empties and
// the list moves up; opening a new heap goes straight to DONE. A free walks
// the list in F_RD and F_CHK passes per range until it merges or finds its
// place, and an insert moves the tail down in INS_LOOP and INS_WR passes per
// range. All this is bound by the single RAM read and write port. A new item
// is taken while the previous result still waits on the output register.
module heap_slot_range_allocator #(
  parameter int MAX_RANGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hsra_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hsra_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsra_pkg::CFG_W-1:0]    cfg_data
);

  localparam int IW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW    = $clog2(MAX_RANGES + 1);
  localparam int DEPTH = hsra_pkg::MAX_HEAPS * (2 ** IW);
  localparam int AW    = hsra_pkg::HEAP_W + IW;
  localparam int RW    = 2 * hsra_pkg::VAL_W;

  typedef enum logic [3:0] {
    IDLE, A_CHK, SH_RD, SH_WR, F_RD, F_CHK, INS_LOOP, INS_WR, DONE
  } state_t;

  state_t                          state;
  logic [hsra_pkg::CFG_W-1:0]      slots_per_heap;
  logic [hsra_pkg::OPEN_W-1:0]     heaps_open;
  logic [CW-1:0]                   range_count [hsra_pkg::MAX_HEAPS];
  logic [hsra_pkg::HEAP_W-1:0]     op_heap;
  logic [hsra_pkg::OFF_W-1:0]      op_off;
  logic [CW-1:0]                   idx;
  logic [CW-1:0]                   pos;
  hsra_pkg::out_item_t             res;

  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  hsra_pkg::range_t                wr_data;
  logic [AW-1:0]                   rd_addr;
  hsra_pkg::range_t                rd_data;

  logic                            first_found;
  logic [hsra_pkg::HEAP_W-1:0]     first_heap;
  logic [hsra_pkg::VAL_W-1:0]      open_size;
  logic [CW-1:0]                   n;
  logic [hsra_pkg::VAL_W-1:0]      s_ext;
  logic [hsra_pkg::VAL_W-1:0]      s_plus;
  logic [hsra_pkg::VAL_W-1:0]      next_start;
  logic [CW-1:0]                   idx_m1;
  logic                            accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != IDLE);
  assign accept    = in_valid && !in_stall;

  assign n          = range_count[op_heap];
  assign s_ext      = {1'b0, op_off};
  assign s_plus     = s_ext + hsra_pkg::VAL_W'(1);
  assign next_start = rd_data.start + hsra_pkg::VAL_W'(1);
  assign idx_m1     = idx - CW'(1);

  always_comb begin
    first_found = 1'b0;
    first_heap  = '0;
    for (int h = 0; h < hsra_pkg::MAX_HEAPS; h++) begin
      if (!first_found && (hsra_pkg::OPEN_W'(h) < heaps_open) && (range_count[h] != '0)) begin
        first_found = 1'b1;
        first_heap  = hsra_pkg::HEAP_W'(h);
      end
    end
  end

  // Heap size is clamped to at least one slot and at most the slot limit.
  always_comb begin
    if (slots_per_heap == '0) begin
      open_size = hsra_pkg::VAL_W'(1);
    end else if (slots_per_heap > hsra_pkg::CFG_W'(hsra_pkg::MAX_SLOTS)) begin
      open_size = hsra_pkg::VAL_W'(hsra_pkg::MAX_SLOTS);
    end else begin
      open_size = slots_per_heap;
    end
  end

  always_comb begin
    unique case (state)
      IDLE:     rd_addr = {first_heap, IW'(0)};
      INS_LOOP: rd_addr = {op_heap, idx_m1[IW-1:0]};
      default:  rd_addr = {op_heap, idx[IW-1:0]};
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {op_heap, idx[IW-1:0]};
    wr_data = rd_data;
    unique case (state)
      IDLE: begin
        wr_addr = {heaps_open[hsra_pkg::HEAP_W-1:0], IW'(0)};
        wr_data = '{start: hsra_pkg::VAL_W'(1), stop: open_size};
        wr_en   = accept && (in_item.kind == hsra_pkg::KIND_ALLOC) && !first_found &&
                  (heaps_open < hsra_pkg::OPEN_W'(hsra_pkg::MAX_HEAPS)) &&
                  (open_size > hsra_pkg::VAL_W'(1));
      end
      A_CHK: begin
        wr_addr = {op_heap, IW'(0)};
        wr_data = '{start: next_start, stop: rd_data.stop};
        wr_en   = (next_start < rd_data.stop);
      end
      SH_WR: begin
        wr_addr = {op_heap, idx_m1[IW-1:0]};
        wr_en   = 1'b1;
      end
      F_CHK: begin
        if (rd_data.start == s_plus) begin
          wr_data = '{start: s_ext, stop: rd_data.stop};
          wr_en   = 1'b1;
        end else if (rd_data.stop == s_ext) begin
          wr_data = '{start: rd_data.start, stop: s_plus};
          wr_en   = 1'b1;
        end
      end
      INS_LOOP: begin
        if (idx <= pos) begin
          wr_addr = {op_heap, pos[IW-1:0]};
          wr_data = '{start: s_ext, stop: s_plus};
          wr_en   = 1'b1;
        end
      end
      INS_WR: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  hsra_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ranges (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      slots_per_heap <= hsra_pkg::CFG_W'(1024);
      heaps_open     <= '0;
      out_valid      <= 1'b0;
      for (int h = 0; h < hsra_pkg::MAX_HEAPS; h++) begin
        range_count[h] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        slots_per_heap <= cfg_data;
      end
      if (out_valid && !out_stall && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            op_heap <= ((in_item.kind == hsra_pkg::KIND_ALLOC) && first_found) ?
                       first_heap : in_item.free_heap;
            op_off  <= in_item.free_offset;
            idx     <= '0;
            if (in_item.kind == hsra_pkg::KIND_ALLOC) begin
              if (first_found) begin
                res   <= '{heap_index: '0, slot_offset: '0, status: hsra_pkg::ST_OK};
                state <= A_CHK;
              end else if (heaps_open >= hsra_pkg::OPEN_W'(hsra_pkg::MAX_HEAPS)) begin
                res   <= '{heap_index: '0, slot_offset: '0,
                           status: hsra_pkg::ST_HEAPS_FULL};
                state <= DONE;
              end else begin
                res <= '{heap_index: heaps_open[hsra_pkg::HEAP_W-1:0], slot_offset: '0,
                         status: hsra_pkg::ST_OK};
                range_count[heaps_open[hsra_pkg::HEAP_W-1:0]] <=
                    (open_size > hsra_pkg::VAL_W'(1)) ? CW'(1) : CW'(0);
                heaps_open <= heaps_open + hsra_pkg::OPEN_W'(1);
                state      <= DONE;
              end
            end else if (hsra_pkg::OPEN_W'(in_item.free_heap) >= heaps_open) begin
              res   <= '{heap_index: '0, slot_offset: '0, status: hsra_pkg::ST_BAD_HEAP};
              state <= DONE;
            end else begin
              res   <= '{heap_index: '0, slot_offset: '0, status: hsra_pkg::ST_OK};
              state <= F_RD;
            end
          end
        end
        A_CHK: begin
          res <= '{heap_index: op_heap, slot_offset: rd_data.start[hsra_pkg::OFF_W-1:0],
                   status: hsra_pkg::ST_OK};
          if (next_start < rd_data.stop) begin
            state <= DONE;
          end else if (n > CW'(1)) begin
            idx   <= CW'(1);
            state <= SH_RD;
          end else begin
            range_count[op_heap] <= n - CW'(1);
            state                <= DONE;
          end
        end
        SH_RD: begin
          state <= SH_WR;
        end
        SH_WR: begin
          // The front range emptied, so every later range moves up one entry.
          if (idx + CW'(1) == n) begin
            range_count[op_heap] <= n - CW'(1);
            state                <= DONE;
          end else begin
            idx   <= idx + CW'(1);
            state <= SH_RD;
          end
        end
        F_RD: begin
          if (idx == n) begin
            if (n >= CW'(MAX_RANGES)) begin
              res.status <= hsra_pkg::ST_TABLE_FULL;
              state      <= DONE;
            end else begin
              pos   <= n;
              state <= INS_LOOP;
            end
          end else begin
            state <= F_CHK;
          end
        end
        F_CHK: begin
          if ((rd_data.start == s_plus) || (rd_data.stop == s_ext)) begin
            state <= DONE;
          end else if (rd_data.start > s_ext) begin
            if (n >= CW'(MAX_RANGES)) begin
              res.status <= hsra_pkg::ST_TABLE_FULL;
              state      <= DONE;
            end else begin
              pos   <= idx;
              idx   <= n;
              state <= INS_LOOP;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= F_RD;
          end
        end
        INS_LOOP: begin
          // Entries from the insert point on move down one, last entry first.
          if (idx > pos) begin
            state <= INS_WR;
          end else begin
            range_count[op_heap] <= n + CW'(1);
            state                <= DONE;
          end
        end
        INS_WR: begin
          idx   <= idx_m1;
          state <= INS_LOOP;
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/hsra_ram.sv =====
module hsra_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANGES    = 16;
  localparam int CYCLE_CAP = 1000000;
  localparam int SETTLE    = 120;

  typedef struct {
    int heap;
    int off;
  } slot_t;

  class slot_scoreboard;
    logic [hsra_pkg::CFG_W-1:0] heap_size_reg;
    int                         heaps_open;
    int                         range_cnt[hsra_pkg::MAX_HEAPS];
    logic [hsra_pkg::VAL_W-1:0] rstart[hsra_pkg::MAX_HEAPS][RANGES];
    logic [hsra_pkg::VAL_W-1:0] rstop[hsra_pkg::MAX_HEAPS][RANGES];
    hsra_pkg::out_item_t        pending_results[$];
    slot_t                      live_slots[$];
    int                         mismatches;

    function void clear();
      heap_size_reg = 11'd1024;
      heaps_open = 0;
      mismatches = 0;
      foreach (range_cnt[h]) range_cnt[h] = 0;
    endfunction

    function logic [1:0] take_slot(output int h, output int off);
      int sz;
      for (h = 0; h < heaps_open; h++)
        if (range_cnt[h] > 0) break;
      if (h >= heaps_open) begin
        if (heaps_open >= hsra_pkg::MAX_HEAPS) return hsra_pkg::ST_HEAPS_FULL;
        h = heaps_open;
        sz = int'(heap_size_reg);
        if (sz == 0) sz = 1;
        if (sz > hsra_pkg::MAX_SLOTS) sz = hsra_pkg::MAX_SLOTS;
        rstart[h][0] = '0;
        rstop[h][0] = hsra_pkg::VAL_W'(sz);
        range_cnt[h] = 1;
        heaps_open++;
      end
      off = int'(rstart[h][0]);
      rstart[h][0] = rstart[h][0] + hsra_pkg::VAL_W'(1);
      if (rstart[h][0] >= rstop[h][0]) begin
        for (int i = 1; i < range_cnt[h]; i++) begin
          rstart[h][i-1] = rstart[h][i];
          rstop[h][i-1] = rstop[h][i];
        end
        range_cnt[h]--;
      end
      return hsra_pkg::ST_OK;
    endfunction

    function logic [1:0] give_slot(int h, int s);
      int n, i;
      if (h >= heaps_open) return hsra_pkg::ST_BAD_HEAP;
      n = range_cnt[h];
      for (i = 0; i < n; i++) begin
        if (int'(rstart[h][i]) == s + 1) begin
          rstart[h][i] = hsra_pkg::VAL_W'(s);
          return hsra_pkg::ST_OK;
        end
        if (int'(rstop[h][i]) == s) begin
          rstop[h][i] = hsra_pkg::VAL_W'(s + 1);
          return hsra_pkg::ST_OK;
        end
        if (int'(rstart[h][i]) > s) break;
      end
      if (n >= RANGES) return hsra_pkg::ST_TABLE_FULL;
      for (int j = n; j > i; j--) begin
        rstart[h][j] = rstart[h][j-1];
        rstop[h][j] = rstop[h][j-1];
      end
      rstart[h][i] = hsra_pkg::VAL_W'(s);
      rstop[h][i] = hsra_pkg::VAL_W'(s + 1);
      range_cnt[h] = n + 1;
      return hsra_pkg::ST_OK;
    endfunction

    function void note_request(hsra_pkg::in_item_t it);
      hsra_pkg::out_item_t r;
      int h, off;
      slot_t sl;
      r = '0;
      if (it.kind == hsra_pkg::KIND_ALLOC) begin
        r.status = take_slot(h, off);
        if (r.status == hsra_pkg::ST_OK) begin
          r.heap_index = hsra_pkg::HEAP_W'(h);
          r.slot_offset = hsra_pkg::OFF_W'(off);
          sl.heap = h;
          sl.off = off;
          live_slots = {live_slots, sl};
        end
      end else begin
        r.status = give_slot(int'(it.free_heap), int'(it.free_offset));
      end
      pending_results = {pending_results, r};
    endfunction

    function void check_result(hsra_pkg::out_item_t got);
      hsra_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.heap_index !== want.heap_index || got.slot_offset !== want.slot_offset ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  hsra_pkg::in_item_t         in_item;
  logic                       out_valid;
  logic                       out_stall;
  hsra_pkg::out_item_t        out_item;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [hsra_pkg::CFG_W-1:0] cfg_data;

  slot_scoreboard sb;
  int             cycles;
  int             send_idle_pct;
  int             stall_pct;

  heap_slot_range_allocator #(.MAX_RANGES(RANGES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("heap_slot_range_allocator verification failed");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);

  task automatic send_request(hsra_pkg::in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 30) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
  endtask

  // Waits for every outstanding result, then lets any trailing work finish.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_heap_size(logic [hsra_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.heap_size_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic hsra_pkg::in_item_t make_item(logic kind, int h, int off);
    hsra_pkg::in_item_t it;
    it.kind = kind;
    it.free_heap = hsra_pkg::HEAP_W'(h);
    it.free_offset = hsra_pkg::OFF_W'(off);
    return it;
  endfunction

  task automatic random_request();
    int pick, idx;
    slot_t sl;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_request(make_item(hsra_pkg::KIND_ALLOC, $urandom_range(7), $urandom_range(1023)));
    end else if (pick < 85 && sb.live_slots.size() > 0) begin
      idx = $urandom_range(sb.live_slots.size() - 1);
      sl = sb.live_slots[idx];
      sb.live_slots.delete(idx);
      send_request(make_item(hsra_pkg::KIND_FREE, sl.heap, sl.off));
    end else if (pick < 93) begin
      // Frees into open heaps at scattered offsets fragment the range lists.
      send_request(make_item(hsra_pkg::KIND_FREE, $urandom_range(sb.heaps_open > 0 ?
                   sb.heaps_open - 1 : 0), $urandom_range(1023)));
    end else begin
      send_request(make_item(hsra_pkg::KIND_FREE, $urandom_range(7), $urandom_range(1023)));
    end
  endtask

  logic [hsra_pkg::CFG_W-1:0] heap_sizes[9] = '{11'd2, 11'd0, 11'd1, 11'd3, 11'd2047,
                                                11'd1024, 11'd5, 11'd1, 11'd9};

  initial begin
    sb = new();
    sb.clear();
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: heap opening, merges at both ends, inserts, unopened heaps.
    write_heap_size(heap_sizes[0]);
    send_request(make_item(hsra_pkg::KIND_FREE, 0, 0));
    send_request(make_item(hsra_pkg::KIND_ALLOC, 7, 1023));
    send_request(make_item(hsra_pkg::KIND_ALLOC, 0, 0));
    send_request(make_item(hsra_pkg::KIND_ALLOC, 0, 0));
    send_request(make_item(hsra_pkg::KIND_FREE, 1, 0));
    send_request(make_item(hsra_pkg::KIND_FREE, 0, 1));
    send_request(make_item(hsra_pkg::KIND_FREE, 0, 0));
    send_request(make_item(hsra_pkg::KIND_FREE, 0, 1023));
    send_request(make_item(hsra_pkg::KIND_FREE, 0, 1020));
    send_request(make_item(hsra_pkg::KIND_FREE, 0, 1021));
    send_request(make_item(hsra_pkg::KIND_FREE, 0, 2));
    send_request(make_item(hsra_pkg::KIND_FREE, 7, 512));
    send_request(make_item(hsra_pkg::KIND_FREE, 2, 341));
    for (int i = 0; i < 8; i++)
      send_request(make_item(hsra_pkg::KIND_ALLOC, 0, 0));

    for (int ph = 1; ph < 9; ph++) begin
      drain();
      write_heap_size(heap_sizes[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int n = 0; n < 190; n++) begin
        if ($urandom_range(199) == 0) drain();
        random_request();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("heap_slot_range_allocator verification clean");
    else
      $display("heap_slot_range_allocator verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/hsra_pkg.sv
rtl/hsra_ram.sv
rtl/heap_slot_range_allocator.sv
tb/sv/testbench.sv
